// ----- design/wod_pkg.sv -----
package wod_pkg;

  // Direction byte layout: left wheel in bits 7:6, right wheel in bits 5:4
  localparam int unsigned LEFT_DIR_HI  = 7;
  localparam int unsigned RIGHT_DIR_HI = 5;

  typedef logic signed [1:0] dir_t;
  typedef logic signed [8:0] sspeed_t;

  localparam dir_t DIR_FWD  = 2'sd1;
  localparam dir_t DIR_BACK = -2'sd1;
  localparam dir_t DIR_NONE = 2'sd0;

  // Decoded wheel part of one frame
  typedef struct packed {
    dir_t        dir;
    sspeed_t     sspeed;
    logic [15:0] enc;
  } wheel_cmd_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic       valid;
    wheel_cmd_t left;
    wheel_cmd_t right;
    logic [7:0] left_pwr;
    logic [7:0] right_pwr;
  } cmd_t;

  // Per-wheel odometry state
  typedef struct packed {
    logic [31:0] total;
    logic [15:0] prev_enc;
    dir_t        prev_dir;
    sspeed_t     prev_speed;
  } wheel_state_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] left_total_ticks;
    logic [31:0] right_total_ticks;
    dir_t        left_heading;
    dir_t        right_heading;
    sspeed_t     left_signed_speed;
    sspeed_t     right_signed_speed;
    logic [7:0]  left_power_out;
    logic [7:0]  right_power_out;
  } result_t;

  // Decode the two direction bits of one wheel: 11 forward, 10 backward
  function automatic dir_t decode_dir(logic [1:0] bits);
    dir_t d;
    if (bits == 2'b11) begin
      d = DIR_FWD;
    end else if (bits[1]) begin
      d = DIR_BACK;
    end else begin
      d = DIR_NONE;
    end
    return d;
  endfunction

endpackage

// ----- design/wheel_odometry_accumulator_core.sv -----
// Wheel odometry accumulator.
// Input channel: present a decoded status frame on the payload ports and raise
// push; the transaction is taken at a clock edge where push is high and full
// is low. Frames with frame_valid low take a slot but change no state.
// Result channel: while empty is low the oldest result sits on the result
// ports; raise pop to take it. Every input transaction yields one result.
// Path: a frame taken at an edge passes the decode stage and the two-entry
// command queue, then execute writes it into a two-entry result buffer, from
// which it reaches the result ports and can be popped.
// Throughput: one frame per cycle when pop is held high; the execute step
// updates both wheel totals together from its own state registers.
// Reset (rst, synchronous): totals, baselines, directions, speeds and power
// bytes clear to zero and both queues empty.
// Stall: when pop stays low the result buffer fills, then the command
// queue and decode stage fill, and full rises; nothing is dropped.
module wheel_odometry_accumulator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               frame_valid,
  input  logic [7:0]         direction_bits,
  input  logic [7:0]         left_speed_mag,
  input  logic [7:0]         right_speed_mag,
  input  logic [15:0]        left_encoder,
  input  logic [15:0]        right_encoder,
  input  logic [7:0]         left_power_in,
  input  logic [7:0]         right_power_in,
  input  logic               pop,
  output logic               empty,
  output logic [31:0]        left_total_ticks,
  output logic [31:0]        right_total_ticks,
  output logic signed [1:0]  left_heading,
  output logic signed [1:0]  right_heading,
  output logic signed [8:0]  left_signed_speed,
  output logic signed [8:0]  right_signed_speed,
  output logic [7:0]         left_power_out,
  output logic [7:0]         right_power_out
);

  logic               cmd_push;
  logic               cmd_full;
  logic               cmd_pop;
  logic               cmd_empty;
  wod_pkg::cmd_t      cmd_in;
  wod_pkg::cmd_t      cmd_out;
  wod_pkg::result_t   result;

  wod_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .frame_valid     (frame_valid),
    .direction_bits  (direction_bits),
    .left_speed_mag  (left_speed_mag),
    .right_speed_mag (right_speed_mag),
    .left_encoder    (left_encoder),
    .right_encoder   (right_encoder),
    .left_power_in   (left_power_in),
    .right_power_in  (right_power_in),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in),
    .cmd_full        (cmd_full)
  );

  wod_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  wod_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign left_total_ticks   = result.left_total_ticks;
  assign right_total_ticks  = result.right_total_ticks;
  assign left_heading       = result.left_heading;
  assign right_heading      = result.right_heading;
  assign left_signed_speed  = result.left_signed_speed;
  assign right_signed_speed = result.right_signed_speed;
  assign left_power_out     = result.left_power_out;
  assign right_power_out    = result.right_power_out;

endmodule

// ----- design/wod_front.sv -----
module wod_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            frame_valid,
  input  logic [7:0]      direction_bits,
  input  logic [7:0]      left_speed_mag,
  input  logic [7:0]      right_speed_mag,
  input  logic [15:0]     left_encoder,
  input  logic [15:0]     right_encoder,
  input  logic [7:0]      left_power_in,
  input  logic [7:0]      right_power_in,
  output logic            cmd_push,
  output wod_pkg::cmd_t   cmd,
  input  logic            cmd_full
);

  logic           stage_valid;
  logic           stage_valid_next;
  wod_pkg::cmd_t  stage;
  wod_pkg::cmd_t  decoded;
  logic           load;

  function automatic wod_pkg::sspeed_t signed_speed(wod_pkg::dir_t d, logic [7:0] spd);
    wod_pkg::sspeed_t s;
    if (d == wod_pkg::DIR_FWD) begin
      s = $signed({1'b0, spd});
    end else if (d == wod_pkg::DIR_BACK) begin
      s = -$signed({1'b0, spd});
    end else begin
      s = '0;
    end
    return s;
  endfunction

  // Classify the incoming frame
  always_comb begin
    decoded.valid       = frame_valid;
    decoded.left.dir    = wod_pkg::decode_dir(
                            direction_bits[wod_pkg::LEFT_DIR_HI -: 2]);
    decoded.right.dir   = wod_pkg::decode_dir(
                            direction_bits[wod_pkg::RIGHT_DIR_HI -: 2]);
    decoded.left.sspeed  = signed_speed(decoded.left.dir, left_speed_mag);
    decoded.right.sspeed = signed_speed(decoded.right.dir, right_speed_mag);
    decoded.left.enc    = left_encoder;
    decoded.right.enc   = right_encoder;
    decoded.left_pwr    = left_power_in;
    decoded.right_pwr   = right_power_in;
  end

  // Hand the stage to the queue; refill when it drains
  assign cmd_push = stage_valid && !cmd_full;
  assign cmd      = stage;
  assign full     = stage_valid && cmd_full;
  assign load     = push && !full;

  always_comb begin
    stage_valid_next = stage_valid;
    if (cmd_push) begin
      stage_valid_next = 1'b0;
    end
    if (load) begin
      stage_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= decoded;
    end
  end

endmodule

// ----- design/wod_cmd_fifo.sv -----
module wod_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wod_pkg::cmd_t  din,
  output logic           full,
  input  logic           pop,
  output wod_pkg::cmd_t  dout,
  output logic           empty
);

  wod_pkg::cmd_t  mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Hold entry payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- design/wod_back.sv -----
module wod_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  wod_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output wod_pkg::result_t   result
);

  wod_pkg::wheel_state_t  left_st;
  wod_pkg::wheel_state_t  right_st;
  wod_pkg::wheel_state_t  left_st_next;
  wod_pkg::wheel_state_t  right_st_next;
  logic [7:0]             left_power_reg;
  logic [7:0]             right_power_reg;
  logic [7:0]             left_power_next;
  logic [7:0]             right_power_next;
  wod_pkg::result_t       res_next;
  wod_pkg::result_t       res_mem [2];
  logic                   out_wr;
  logic                   out_rd;
  logic [1:0]             out_count;
  logic                   out_pop;

  function automatic wod_pkg::wheel_state_t step_wheel(wod_pkg::wheel_state_t s,
                                                       wod_pkg::wheel_cmd_t w);
    wod_pkg::wheel_state_t n;
    logic                  zero_base;
    logic [15:0]           base;
    logic [15:0]           diff;
    zero_base = (w.dir == wod_pkg::DIR_NONE) || (w.dir != s.prev_dir) ||
                ((s.prev_speed == '0) && (w.sspeed != '0));
    base = zero_base ? 16'd0 : s.prev_enc;
    diff = (w.enc >= base) ? (w.enc - base) : (base - w.enc);
    n = s;
    if (w.dir != wod_pkg::DIR_NONE) begin
      n.total = s.total + {16'd0, diff};
    end
    n.prev_enc   = w.enc;
    n.prev_dir   = w.dir;
    n.prev_speed = w.sspeed;
    return n;
  endfunction

  // Execute when the result buffer has room
  assign cmd_pop = !cmd_empty && (out_count != 2'd2);
  assign empty   = (out_count == 2'd0);
  assign out_pop = pop && !empty;
  assign result  = res_mem[out_rd];

  // Update odometry; an invalid frame leaves state as is
  always_comb begin
    left_st_next     = left_st;
    right_st_next    = right_st;
    left_power_next  = left_power_reg;
    right_power_next = right_power_reg;
    if (cmd.valid) begin
      left_st_next     = step_wheel(left_st, cmd.left);
      right_st_next    = step_wheel(right_st, cmd.right);
      left_power_next  = cmd.left_pwr;
      right_power_next = cmd.right_pwr;
    end
  end

  // Form the result transaction
  always_comb begin
    res_next.left_total_ticks   = left_st_next.total;
    res_next.right_total_ticks  = right_st_next.total;
    res_next.left_heading       = left_st_next.prev_dir;
    res_next.right_heading      = right_st_next.prev_dir;
    res_next.left_signed_speed  = left_st_next.prev_speed;
    res_next.right_signed_speed = right_st_next.prev_speed;
    res_next.left_power_out     = left_power_next;
    res_next.right_power_out    = right_power_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_st         <= '0;
      right_st        <= '0;
      left_power_reg  <= 8'd0;
      right_power_reg <= 8'd0;
    end else if (cmd_pop) begin
      left_st         <= left_st_next;
      right_st        <= right_st_next;
      left_power_reg  <= left_power_next;
      right_power_reg <= right_power_next;
    end
  end

  // Advance result buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (cmd_pop) begin
        out_wr <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      out_count <= out_count + {1'b0, cmd_pop} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_mem[out_wr] <= res_next;
    end
  end

endmodule

// ----- design/wod_checker.sv -----
module wod_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop,
  input  logic               empty,
  input  logic [31:0]        left_total_ticks,
  input  logic signed [1:0]  left_heading,
  input  logic signed [1:0]  right_heading,
  input  logic signed [8:0]  left_signed_speed,
  input  logic signed [8:0]  right_signed_speed
);

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered right after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(left_total_ticks) && $stable(left_heading)))
    else $error("stalled result changed");

  // Direction is never the unused code
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (left_heading != 2'sb10 && right_heading != 2'sb10))
    else $error("direction holds unused code");

  // No direction means no speed
  a_left_still: assert property (@(posedge clk) disable iff (rst)
    (!empty && left_heading == 2'sd0) |-> left_signed_speed == 9'sd0)
    else $error("left speed without direction");

  a_right_still: assert property (@(posedge clk) disable iff (rst)
    (!empty && right_heading == 2'sd0) |-> right_signed_speed == 9'sd0)
    else $error("right speed without direction");

endmodule

bind wheel_odometry_accumulator_core wod_checker u_wod_checker (
  .clk                (clk),
  .rst                (rst),
  .pop                (pop),
  .empty              (empty),
  .left_total_ticks   (left_total_ticks),
  .left_heading       (left_heading),
  .right_heading      (right_heading),
  .left_signed_speed  (left_signed_speed),
  .right_signed_speed (right_signed_speed)
);

// ----- bench/tb_wheel_odometry_accumulator_core.sv -----
`timescale 1ns / 1ps

module tb_wheel_odometry_accumulator_core;

  localparam int STALL_CYCLES = 60;
  localparam int RANDOM_FRAMES = 770;

  // One status frame as offered on the input side
  typedef struct {
    bit          valid;
    logic [7:0]  dir_bits;
    logic [7:0]  l_spd;
    logic [7:0]  r_spd;
    logic [15:0] l_enc;
    logic [15:0] r_enc;
    logic [7:0]  l_pwr;
    logic [7:0]  r_pwr;
  } frame_t;

  // Directed row: frame plus a hand-written reading where one is given
  typedef struct {
    frame_t           f;
    bit               typed;
    wod_pkg::result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic frame_valid = 1'b0;
  logic [7:0] direction_bits = '0;
  logic [7:0] left_speed_mag = '0;
  logic [7:0] right_speed_mag = '0;
  logic [15:0] left_encoder = '0;
  logic [15:0] right_encoder = '0;
  logic [7:0] left_power_in = '0;
  logic [7:0] right_power_in = '0;
  logic pop = 1'b0;
  logic empty;
  logic [31:0] left_total_ticks;
  logic [31:0] right_total_ticks;
  logic signed [1:0] left_heading;
  logic signed [1:0] right_heading;
  logic signed [8:0] left_signed_speed;
  logic signed [8:0] right_signed_speed;
  logic [7:0] left_power_out;
  logic [7:0] right_power_out;

  // Odometry state mirrored by the predictor
  wod_pkg::wheel_state_t left_wheel = '0;
  wod_pkg::wheel_state_t right_wheel = '0;
  logic [7:0] left_power_seen = '0;
  logic [7:0] right_power_seen = '0;

  wod_pkg::result_t expected_readings[$];
  stim_row_t stim_rows[$];
  int mismatch_cnt = 0;
  int idle_pct = 13;
  bit hold_req = 1'b0;

  wheel_odometry_accumulator_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .frame_valid        (frame_valid),
    .direction_bits     (direction_bits),
    .left_speed_mag     (left_speed_mag),
    .right_speed_mag    (right_speed_mag),
    .left_encoder       (left_encoder),
    .right_encoder      (right_encoder),
    .left_power_in      (left_power_in),
    .right_power_in     (right_power_in),
    .pop                (pop),
    .empty              (empty),
    .left_total_ticks   (left_total_ticks),
    .right_total_ticks  (right_total_ticks),
    .left_heading       (left_heading),
    .right_heading      (right_heading),
    .left_signed_speed  (left_signed_speed),
    .right_signed_speed (right_signed_speed),
    .left_power_out     (left_power_out),
    .right_power_out    (right_power_out)
  );

  always #5 clk = ~clk;

  // Map two direction bits to a wheel direction: 11 forward, 10 backward
  function automatic wod_pkg::dir_t wheel_dir(logic [1:0] b);
    if (b == 2'b11) return wod_pkg::DIR_FWD;
    if (b == 2'b10) return wod_pkg::DIR_BACK;
    return wod_pkg::DIR_NONE;
  endfunction

  // Advance one wheel: pick the baseline, then add the absolute encoder delta
  function automatic void advance_wheel(input wod_pkg::dir_t d, input logic [7:0] spd,
                                        input logic [15:0] enc,
                                        inout wod_pkg::wheel_state_t w);
    wod_pkg::sspeed_t ss;
    logic [15:0] base;
    logic [15:0] delta;
    ss = wod_pkg::sspeed_t'(int'(d) * int'(spd));
    base = w.prev_enc;
    if (d == wod_pkg::DIR_NONE || d != w.prev_dir || (w.prev_speed == 0 && ss != 0)) begin
      base = 16'd0;
    end
    delta = (enc >= base) ? enc - base : base - enc;
    if (d != wod_pkg::DIR_NONE) begin
      w.total = w.total + {16'd0, delta};
    end
    w.prev_enc = enc;
    w.prev_speed = ss;
    w.prev_dir = d;
  endfunction

  // Apply one accepted frame and return the reading it produces
  function automatic wod_pkg::result_t odometry_step(frame_t f);
    wod_pkg::result_t r;
    if (f.valid) begin
      advance_wheel(wheel_dir(f.dir_bits[7:6]), f.l_spd, f.l_enc, left_wheel);
      advance_wheel(wheel_dir(f.dir_bits[5:4]), f.r_spd, f.r_enc, right_wheel);
      left_power_seen = f.l_pwr;
      right_power_seen = f.r_pwr;
    end
    r.left_total_ticks = left_wheel.total;
    r.right_total_ticks = right_wheel.total;
    r.left_heading = left_wheel.prev_dir;
    r.right_heading = right_wheel.prev_dir;
    r.left_signed_speed = left_wheel.prev_speed;
    r.right_signed_speed = right_wheel.prev_speed;
    r.left_power_out = left_power_seen;
    r.right_power_out = right_power_seen;
    return r;
  endfunction

  function automatic frame_t frame_of(bit v, logic [7:0] d, logic [7:0] ls,
                                      logic [7:0] rs, logic [15:0] le,
                                      logic [15:0] re, logic [7:0] lp,
                                      logic [7:0] rp);
    frame_t f;
    f.valid = v;
    f.dir_bits = d;
    f.l_spd = ls;
    f.r_spd = rs;
    f.l_enc = le;
    f.r_enc = re;
    f.l_pwr = lp;
    f.r_pwr = rp;
    return f;
  endfunction

  function automatic wod_pkg::result_t reading_of(logic [31:0] lt, logic [31:0] rt,
                                                  wod_pkg::dir_t ld, wod_pkg::dir_t rd,
                                                  wod_pkg::sspeed_t lss,
                                                  wod_pkg::sspeed_t rss,
                                                  logic [7:0] lp, logic [7:0] rp);
    wod_pkg::result_t r;
    r.left_total_ticks = lt;
    r.right_total_ticks = rt;
    r.left_heading = ld;
    r.right_heading = rd;
    r.left_signed_speed = lss;
    r.right_signed_speed = rss;
    r.left_power_out = lp;
    r.right_power_out = rp;
    return r;
  endfunction

  // Mostly forward or backward, sometimes any code
  function automatic logic [1:0] pick_dir();
    if ($urandom_range(99) < 85) return ($urandom_range(1) != 0) ? 2'b11 : 2'b10;
    return 2'($urandom);
  endfunction

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Offer one frame, hold it until accepted, then record its reading
  task automatic offer_frame(input frame_t f, input bit typed,
                             input wod_pkg::result_t want);
    wod_pkg::result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    frame_valid <= f.valid;
    direction_bits <= f.dir_bits;
    left_speed_mag <= f.l_spd;
    right_speed_mag <= f.r_spd;
    left_encoder <= f.l_enc;
    right_encoder <= f.r_enc;
    left_power_in <= f.l_pwr;
    right_power_in <= f.r_pwr;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = odometry_step(f);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait until every reading has come back
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Result side: check each popped transaction, stall at random or on request
  initial begin : reader
    wod_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with no expected reading");
          mismatch_cnt++;
        end else begin
          want = expected_readings.pop_front();
          check_field("left_total_ticks", want.left_total_ticks, left_total_ticks);
          check_field("right_total_ticks", want.right_total_ticks, right_total_ticks);
          check_field("left_heading", want.left_heading, left_heading);
          check_field("right_heading", want.right_heading, right_heading);
          check_field("left_signed_speed", want.left_signed_speed, left_signed_speed);
          check_field("right_signed_speed", want.right_signed_speed, right_signed_speed);
          check_field("left_power_out", want.left_power_out, left_power_out);
          check_field("right_power_out", want.right_power_out, right_power_out);
        end
      end
      if (hold_req) begin
        pop <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    frame_t f;
    wod_pkg::result_t zero_reading;
    logic [3:0] run_dirs;
    logic [7:0] run_lspd;
    logic [7:0] run_rspd;
    logic [15:0] lenc;
    logic [15:0] renc;
    int run_left;
    int valid_sent;
    int roll;
    bit held;

    zero_reading = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: reset state, extremes, direction codes, baseline cases
    stim_rows.push_back('{frame_of(0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                   8'hFF, 8'hFF), 1'b1, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hF0, 8'hFF, 8'hFF, 16'hFFFF, 16'h0001,
                                   8'hFF, 8'h00), 1'b1,
                          reading_of(32'd65535, 32'd1, wod_pkg::DIR_FWD,
                                     wod_pkg::DIR_FWD, 9'sd255, 9'sd255,
                                     8'hFF, 8'h00)});
    stim_rows.push_back('{frame_of(1, 8'hA0, 8'hFF, 8'h01, 16'h0000, 16'h0000,
                                   8'h00, 8'hFF), 1'b1,
                          reading_of(32'd65535, 32'd1, wod_pkg::DIR_BACK,
                                     wod_pkg::DIR_BACK, -9'sd255, -9'sd1,
                                     8'h00, 8'hFF)});
    stim_rows.push_back('{frame_of(1, 8'h5F, 8'hC8, 8'hC8, 16'd1234, 16'd4321,
                                   8'h5A, 8'hA5), 1'b1,
                          reading_of(32'd65535, 32'd1, wod_pkg::DIR_NONE,
                                     wod_pkg::DIR_NONE, 9'sd0, 9'sd0,
                                     8'h5A, 8'hA5)});
    stim_rows.push_back('{frame_of(0, 8'hF0, 8'h11, 8'h22, 16'h7777, 16'h8888,
                                   8'h33, 8'h44), 1'b1,
                          reading_of(32'd65535, 32'd1, wod_pkg::DIR_NONE,
                                     wod_pkg::DIR_NONE, 9'sd0, 9'sd0,
                                     8'h5A, 8'hA5)});
    stim_rows.push_back('{frame_of(1, 8'hE0, 8'd0, 8'd0, 16'd100, 16'd200,
                                   8'h01, 8'h02), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hE3, 8'd10, 8'd10, 16'd150, 16'd180,
                                   8'h03, 8'h04), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hEC, 8'd10, 8'd10, 16'd170, 16'd50,
                                   8'h05, 8'h06), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hE0, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000,
                                   8'h07, 8'h08), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hE0, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF,
                                   8'h09, 8'h0A), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hB0, 8'd40, 8'd40, 16'd300, 16'd300,
                                   8'h0B, 8'h0C), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hB0, 8'd0, 8'd0, 16'd5, 16'd5,
                                   8'h0D, 8'h0E), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hB0, 8'd7, 8'd7, 16'd9, 16'd1,
                                   8'h0F, 8'h10), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hC5, 8'd20, 8'd20, 16'd60, 16'd60,
                                   8'h11, 8'h12), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'h3A, 8'd20, 8'd20, 16'd70, 16'd70,
                                   8'h13, 8'h14), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'h90, 8'd33, 8'd33, 16'd80, 16'd80,
                                   8'h15, 8'h16), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'h60, 8'd33, 8'd33, 16'd90, 16'd90,
                                   8'h17, 8'h18), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(0, 8'h00, 8'hAA, 8'h55, 16'hAAAA, 16'h5555,
                                   8'hAA, 8'h55), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hFF, 8'h80, 8'h80, 16'h8000, 16'h7FFF,
                                   8'h80, 8'h7F), 1'b0, zero_reading});
    stim_rows.push_back('{frame_of(1, 8'hFF, 8'h80, 8'h80, 16'h7FFF, 16'h8000,
                                   8'h7F, 8'h80), 1'b0, zero_reading});
    foreach (stim_rows[i]) offer_frame(stim_rows[i].f, stim_rows[i].typed, stim_rows[i].want);
    wait_drained();

    // Random runs of steady motion with noise, invalid frames and broken runs
    run_left = 0;
    valid_sent = 0;
    held = 1'b0;
    lenc = 16'($urandom);
    renc = 16'($urandom);
    run_dirs = '0;
    run_lspd = '0;
    run_rspd = '0;
    while (valid_sent < RANDOM_FRAMES) begin
      if (run_left == 0) begin
        run_left = $urandom_range(30, 3);
        run_dirs = {pick_dir(), pick_dir()};
        run_lspd = 8'($urandom_range(255, 1));
        run_rspd = 8'($urandom_range(255, 1));
      end
      run_left--;
      // stall the result side once while frames keep coming
      if (valid_sent == 200 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      idle_pct = (valid_sent >= 400 && valid_sent < 550) ? 0 : 13;
      f.valid = ($urandom_range(99) >= 8);
      f.dir_bits = {run_dirs, 4'($urandom)};
      if ($urandom_range(99) < 5) f.dir_bits = 8'($urandom);
      roll = $urandom_range(99);
      f.l_spd = (roll < 10) ? 8'd0 : (roll < 15) ? 8'hFF : run_lspd;
      roll = $urandom_range(99);
      f.r_spd = (roll < 10) ? 8'd0 : (roll < 15) ? 8'hFF : run_rspd;
      if ($urandom_range(99) < 75) begin
        lenc = ($urandom_range(1) != 0) ? lenc + 16'($urandom_range(400))
                                        : lenc - 16'($urandom_range(400));
      end else begin
        lenc = 16'($urandom);
      end
      if ($urandom_range(99) < 75) begin
        renc = ($urandom_range(1) != 0) ? renc + 16'($urandom_range(400))
                                        : renc - 16'($urandom_range(400));
      end else begin
        renc = 16'($urandom);
      end
      f.l_enc = lenc;
      f.r_enc = renc;
      f.l_pwr = 8'($urandom);
      f.r_pwr = 8'($urandom);
      offer_frame(f, 1'b0, zero_reading);
      if (f.valid) valid_sent++;
    end
    idle_pct = 13;
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
